FILE: design/sspp_pkg.sv
package sspp_pkg;

  // receive phase codes
  localparam logic [2:0] PH_SYNC   = 3'd0;
  localparam logic [2:0] PH_ID     = 3'd1;
  localparam logic [2:0] PH_LENGTH = 3'd2;
  localparam logic [2:0] PH_STATUS = 3'd3;
  localparam logic [2:0] PH_PARAMS = 3'd4;
  localparam logic [2:0] PH_CHECK  = 3'd5;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  // lengths up to this value carry no parameter bytes
  localparam logic [7:0] LEN_OVERHEAD = 8'd2;

  // result kinds
  localparam logic KIND_PARAM  = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  // packet outcomes
  localparam logic [1:0] OUT_OK         = 2'd0;
  localparam logic [1:0] OUT_BAD_ID     = 2'd1;
  localparam logic [1:0] OUT_BAD_CSUM   = 2'd2;
  localparam logic [1:0] OUT_STATUS_ERR = 2'd3;

  typedef struct packed {
    logic [2:0] phase;
    logic       last_ff;
    logic [7:0] len;
    logic [7:0] status;
    logic [7:0] sum;
    logic [7:0] left;
  } state_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] pbyte;
    logic [7:0] pindex;
    logic [1:0] outcome;
    logic [7:0] status;
    logic [7:0] len;
  } res_t;

endpackage

FILE: design/sspp_step.sv
// Next-state and result logic for one received byte.
module sspp_step (
  input  sspp_pkg::state_t st_i,
  input  logic [7:0]       rx_byte_i,
  input  logic [7:0]       expected_id_i,
  output sspp_pkg::state_t st_o,
  output logic             has_res_o,
  output sspp_pkg::res_t   res_o
);
  import sspp_pkg::*;

  logic [7:0] plen;
  logic [7:0] expect_sum;

  assign plen       = st_i.len - LEN_OVERHEAD;
  assign expect_sum = ~st_i.sum;

  always_comb begin
    st_o      = st_i;
    has_res_o = 1'b0;
    res_o     = '0;
    case (st_i.phase)
      PH_ID: begin
        if (rx_byte_i != expected_id_i) begin
          st_o.phase    = PH_SYNC;
          st_o.last_ff  = 1'b0;
          has_res_o     = 1'b1;
          res_o.kind    = KIND_FINISH;
          res_o.outcome = OUT_BAD_ID;
        end else begin
          st_o.sum   = rx_byte_i;
          st_o.phase = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        st_o.len   = rx_byte_i;
        st_o.sum   = st_i.sum + rx_byte_i;
        st_o.phase = PH_STATUS;
      end
      PH_STATUS: begin
        st_o.status = rx_byte_i;
        st_o.sum    = st_i.sum + rx_byte_i;
        if (st_i.len > LEN_OVERHEAD) begin
          st_o.left  = plen;
          st_o.phase = PH_PARAMS;
        end else begin
          st_o.left  = '0;
          st_o.phase = PH_CHECK;
        end
      end
      PH_PARAMS: begin
        st_o.sum  = st_i.sum + rx_byte_i;
        st_o.left = st_i.left - 8'd1;
        if (st_i.left == 8'd1) st_o.phase = PH_CHECK;
        has_res_o    = 1'b1;
        res_o.kind   = KIND_PARAM;
        res_o.pbyte  = rx_byte_i;
        res_o.pindex = plen - st_i.left;
        res_o.status = st_i.status;
        res_o.len    = st_i.len;
      end
      PH_CHECK: begin
        st_o.phase   = PH_SYNC;
        st_o.last_ff = 1'b0;
        has_res_o    = 1'b1;
        res_o.kind   = KIND_FINISH;
        res_o.status = st_i.status;
        res_o.len    = st_i.len;
        if (expect_sum != rx_byte_i)  res_o.outcome = OUT_BAD_CSUM;
        else if (st_i.status != '0)   res_o.outcome = OUT_STATUS_ERR;
        else                          res_o.outcome = OUT_OK;
      end
      default: begin
        // hunting, unused codes included
        if (rx_byte_i == SYNC_BYTE && st_i.last_ff) begin
          st_o.phase   = PH_ID;
          st_o.last_ff = 1'b0;
        end else begin
          st_o.phase   = PH_SYNC;
          st_o.last_ff = (rx_byte_i == SYNC_BYTE);
        end
      end
    endcase
  end

endmodule

FILE: design/servo_status_packet_parser_core.sv
// Status packet receiver for a serial servo bus. One received byte is taken
// per beat on in_*; the parser hunts for two 0xFF sync bytes, checks the id
// against cfg-written expected_id (reset 1), then takes length, status,
// length-2 parameter bytes and the checksum (inverted 8-bit sum of id,
// length, status and parameters). Each parameter byte leaves as a result
// beat with result_kind 0; the end of a packet, or a wrong id, leaves as a
// beat with result_kind 1 and the outcome. Sync, length, status and matching
// id bytes produce no result. Every byte is handled in the cycle it is
// accepted, so one byte per clock is sustained while in_stall is low; a result
// appears on out_* in the cycle after its byte is accepted. in_stall rises only
// while a result sits in the output register and the consumer stalls it.
// expected_id must only be written while no packet is in flight.
module servo_status_packet_parser_core (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  // byte input
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  // result output
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_result_kind,
  output logic [7:0] out_param_byte,
  output logic [7:0] out_param_index,
  output logic [1:0] out_outcome,
  output logic [7:0] out_status_byte,
  output logic [7:0] out_length_byte
);
  import sspp_pkg::*;

  logic [7:0] expected_id_r;
  state_t     st_r;
  state_t     st_nxt;
  logic       has_res;
  res_t       res;
  res_t       res_r;
  logic       out_valid_r;
  logic       in_acc;

  // the output register frees up in the same cycle it is drained
  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  sspp_step u_step (
    .st_i          (st_r),
    .rx_byte_i     (in_rx_byte),
    .expected_id_i (expected_id_r),
    .st_o          (st_nxt),
    .has_res_o     (has_res),
    .res_o         (res)
  );

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_id_r <= 8'd1;
    end else if (cfg_wr_en) begin
      expected_id_r <= cfg_wr_data;
    end
  end

  // parser state, advanced on every accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && has_res) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && has_res) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = res_r.kind;
  assign out_param_byte  = res_r.pbyte;
  assign out_param_index = res_r.pindex;
  assign out_outcome     = res_r.outcome;
  assign out_status_byte = res_r.status;
  assign out_length_byte = res_r.len;

endmodule

FILE: design/sspp_checker.sv
module sspp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_result_kind,
  input logic [7:0] out_param_byte,
  input logic [7:0] out_param_index,
  input logic [1:0] out_outcome,
  input logic [7:0] out_status_byte,
  input logic [7:0] out_length_byte
);
  import sspp_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_kind)
      && $stable(out_outcome) && $stable(out_param_byte))
    else $error("stalled result beat changed");

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  a_param_no_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_PARAM |-> out_outcome == OUT_OK)
    else $error("parameter beat carries an outcome");

  a_finish_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_FINISH
      |-> out_param_byte == 8'd0 && out_param_index == 8'd0)
    else $error("finish beat carries parameter data");

  a_bad_id_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_FINISH && out_outcome == OUT_BAD_ID
      |-> out_status_byte == 8'd0 && out_length_byte == 8'd0)
    else $error("bad id beat carries packet fields");

endmodule

bind servo_status_packet_parser_core sspp_checker u_sspp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_result_kind (out_result_kind),
  .out_param_byte  (out_param_byte),
  .out_param_index (out_param_index),
  .out_outcome     (out_outcome),
  .out_status_byte (out_status_byte),
  .out_length_byte (out_length_byte)
);
